/* rtl/core/assert_macros.svh */
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/fskm_pkg.sv */
package fskm_pkg;

    localparam int SAMPLES_PER_TICK  = 10;
    localparam int MAX_CARRIER_TICKS = 25920000;

    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int TICKS_W  = 25;
    localparam int SAMPLE_W = 16;
    localparam int FMT_W    = 9;
    localparam int AMP_W    = 15;

    // samples left in a segment and phase within one tone period
    localparam int SL_W = $clog2((2 ** TICKS_W - 1) * SAMPLES_PER_TICK + 1);
    localparam int PH_W = $clog2(4 * SAMPLES_PER_TICK + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = AMP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 1'b1;

    localparam logic [FMT_W-1:0] FRAME_FORMAT_RESET = 9'd332;
    localparam logic [AMP_W-1:0] AMPLITUDE_RESET    = 15'h6000;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CARRIER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_CARRIER,
        KIND_TICK
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   data_byte;
        logic                carrier_mark;
        logic [TICKS_W-1:0]  carrier_ticks;
    } t_item;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_qstat;

endpackage

/* rtl/core/fskm_front.sv */
module fskm_front (
    input  logic                          i_valid,
    input  logic [fskm_pkg::MODE_W-1:0]   i_mode,
    input  logic [fskm_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_carrier_mark,
    input  logic [fskm_pkg::TICKS_W-1:0]  i_carrier_ticks,
    input  fskm_pkg::t_qstat              i_qstat,
    output logic                          o_stall,
    output logic                          o_push,
    output fskm_pkg::t_item               o_item
);

    logic w_keep;

    // unused mode and zero-length carriers never reach the queue
    always_comb begin
        o_item.data_byte     = i_data_byte;
        o_item.carrier_mark  = i_carrier_mark;
        o_item.carrier_ticks = i_carrier_ticks;
        o_item.kind          = fskm_pkg::KIND_TICK;
        w_keep               = 1'b0;
        unique case (i_mode)
            fskm_pkg::MODE_LOAD: begin
                o_item.kind = fskm_pkg::KIND_LOAD;
                w_keep      = 1'b1;
            end
            fskm_pkg::MODE_CARRIER: begin
                o_item.kind = fskm_pkg::KIND_CARRIER;
                w_keep      = (i_carrier_ticks != '0);
            end
            fskm_pkg::MODE_TICK: begin
                o_item.kind = fskm_pkg::KIND_TICK;
                w_keep      = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full && w_keep;

endmodule

/* rtl/core/fskm_queue.sv */
module fskm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fskm_pkg::t_item  i_item,
    input  logic             i_pop,
    output fskm_pkg::t_item  o_item,
    output fskm_pkg::t_qstat o_qstat
);

    fskm_pkg::t_item                 r_mem [fskm_pkg::QUEUE_DEPTH];
    logic [fskm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [fskm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [fskm_pkg::QCNT_W-1:0]     r_count;
    logic [fskm_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [fskm_pkg::QPTR_W-1:0]     n_rd_ptr;
    logic [fskm_pkg::QCNT_W-1:0]     n_count;

    localparam logic [fskm_pkg::QPTR_W-1:0] LAST_PTR =
        fskm_pkg::QPTR_W'(fskm_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == fskm_pkg::QCNT_W'(fskm_pkg::QUEUE_DEPTH));
    assign o_qstat.count = r_count;

endmodule

/* rtl/core/fskm_back.sv */
module fskm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fskm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fskm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  fskm_pkg::t_qstat                 i_qstat,
    input  fskm_pkg::t_item                  i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [fskm_pkg::SAMPLE_W-1:0] o_sample,
    output logic                             o_segment_last,
    output logic                             o_idle
);

    typedef enum logic [1:0] {
        ACT_IDLE,
        ACT_FRAME,
        ACT_CARRIER
    } t_activity;

    localparam int SPT = fskm_pkg::SAMPLES_PER_TICK;
    localparam int SEG_TICKS_W = 5;

    t_activity                        r_act, n_act;
    logic [fskm_pkg::FMT_W-1:0]       r_fmt_cfg, n_fmt_cfg;
    logic [fskm_pkg::AMP_W-1:0]       r_amp, n_amp;
    logic [fskm_pkg::FMT_W-1:0]       r_fmt, n_fmt;
    logic [fskm_pkg::BYTE_W-1:0]      r_shift, n_shift;
    logic [3:0]                       r_bp, n_bp;
    logic                             r_par, n_par;
    logic                             r_tone, n_tone;
    logic [fskm_pkg::PH_W-1:0]        r_phase, n_phase;
    logic [fskm_pkg::SL_W-1:0]        r_sl, n_sl;
    logic                             r_valid, n_valid;
    logic [fskm_pkg::SAMPLE_W-1:0]    r_sample, n_sample;
    logic                             r_last, n_last;
    logic                             r_idle, n_idle;

    logic                             w_out_free;
    logic                             w_have;
    logic [fskm_pkg::PH_W-1:0]        w_half;
    logic [fskm_pkg::PH_W-1:0]        w_phase_inc;
    logic [fskm_pkg::SL_W-1:0]        w_sl_dec;
    logic [3:0]                       w_dcount;
    logic [3:0]                       w_bp_inc;
    logic [SEG_TICKS_W-1:0]           w_bit_ticks;
    logic [SEG_TICKS_W-1:0]           w_stop_ticks;
    logic [fskm_pkg::SAMPLE_W-1:0]    w_pos;
    logic                             w_bit;

    function automatic logic [fskm_pkg::SL_W-1:0] seg_samples(
        input logic [fskm_pkg::TICKS_W-1:0] ticks
    );
        seg_samples = fskm_pkg::SL_W'(ticks) * fskm_pkg::SL_W'(SPT);
    endfunction

    function automatic logic [SEG_TICKS_W-1:0] ticks_per_bit(
        input logic [fskm_pkg::FMT_W-1:0] fmt
    );
        ticks_per_bit = fmt[8] ? SEG_TICKS_W'(4) : SEG_TICKS_W'(8);
    endfunction

    assign w_out_free  = !r_valid || !i_stall;
    assign w_have      = !i_qstat.empty;
    assign o_pop       = w_have && ((i_item.kind != fskm_pkg::KIND_TICK) || w_out_free);

    assign w_half      = r_tone ? fskm_pkg::PH_W'(SPT) : fskm_pkg::PH_W'(2 * SPT);
    assign w_phase_inc = r_phase + 1'b1;
    assign w_sl_dec    = (r_sl != '0) ? r_sl - 1'b1 : '0;
    assign w_dcount    = 4'd5 + {2'b00, r_fmt[3:2]};
    assign w_bp_inc    = r_bp + 1'b1;
    assign w_bit_ticks = ticks_per_bit(r_fmt);
    assign w_pos       = {1'b0, r_amp};
    assign w_bit       = r_shift[0];

    // stop segment: one, one and a half or two bit times
    always_comb begin
        unique case (r_fmt[7:6])
            2'd1:    w_stop_ticks = w_bit_ticks;
            2'd2:    w_stop_ticks = w_bit_ticks + (w_bit_ticks >> 1);
            default: w_stop_ticks = w_bit_ticks << 1;
        endcase
    end

    always_comb begin
        n_act     = r_act;
        n_fmt_cfg = r_fmt_cfg;
        n_amp     = r_amp;
        n_fmt     = r_fmt;
        n_shift   = r_shift;
        n_bp      = r_bp;
        n_par     = r_par;
        n_tone    = r_tone;
        n_phase   = r_phase;
        n_sl      = r_sl;
        n_valid   = r_valid && i_stall;
        n_sample  = r_sample;
        n_last    = r_last;
        n_idle    = r_idle;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fskm_pkg::CFG_FRAME_FORMAT: n_fmt_cfg = i_cfg_data[fskm_pkg::FMT_W-1:0];
                fskm_pkg::CFG_AMPLITUDE:    n_amp     = i_cfg_data[fskm_pkg::AMP_W-1:0];
                default: ;
            endcase
        end

        if (o_pop) begin
            unique case (i_item.kind)
                fskm_pkg::KIND_LOAD: begin
                    if (r_act == ACT_IDLE) begin
                        n_fmt   = r_fmt_cfg;
                        n_shift = i_item.data_byte;
                        n_bp    = '0;
                        n_par   = 1'b0;
                        n_tone  = 1'b0;
                        n_phase = '0;
                        n_sl    = seg_samples(fskm_pkg::TICKS_W'(ticks_per_bit(r_fmt_cfg)));
                        n_act   = ACT_FRAME;
                    end
                end
                fskm_pkg::KIND_CARRIER: begin
                    if (r_act == ACT_IDLE) begin
                        n_tone  = i_item.carrier_mark;
                        n_phase = '0;
                        n_sl    = seg_samples(i_item.carrier_ticks);
                        n_act   = ACT_CARRIER;
                    end
                end
                fskm_pkg::KIND_TICK: begin
                    n_valid = 1'b1;
                    if (r_act == ACT_IDLE) begin
                        n_sample = '0;
                        n_last   = 1'b0;
                        n_idle   = 1'b1;
                    end else begin
                        n_sample = (r_phase < w_half) ? w_pos : -w_pos;
                        n_last   = 1'b0;
                        n_idle   = 1'b0;
                        n_phase  = (w_phase_inc >= (w_half << 1)) ? '0 : w_phase_inc;
                        n_sl     = w_sl_dec;
                        if (w_sl_dec == '0) begin
                            if (r_act == ACT_CARRIER || r_bp >= w_dcount + 4'd2) begin
                                n_act   = ACT_IDLE;
                                n_sl    = '0;
                                n_phase = '0;
                                n_last  = 1'b1;
                            end else if (w_bp_inc <= w_dcount) begin
                                n_bp    = w_bp_inc;
                                n_shift = r_shift >> 1;
                                n_par   = r_par ^ w_bit;
                                n_tone  = w_bit;
                                n_phase = '0;
                                n_sl    = seg_samples(fskm_pkg::TICKS_W'(w_bit_ticks));
                            end else if (w_bp_inc == w_dcount + 4'd1 && r_fmt[4]) begin
                                // parity bit: even keeps the running ones count
                                n_bp    = w_bp_inc;
                                n_tone  = r_fmt[5] ? r_par : !r_par;
                                n_phase = '0;
                                n_sl    = seg_samples(fskm_pkg::TICKS_W'(w_bit_ticks));
                            end else begin
                                n_bp    = w_dcount + 4'd2;
                                n_tone  = 1'b1;
                                n_phase = '0;
                                n_sl    = seg_samples(fskm_pkg::TICKS_W'(w_stop_ticks));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= ACT_IDLE;
            r_fmt_cfg <= fskm_pkg::FRAME_FORMAT_RESET;
            r_amp     <= fskm_pkg::AMPLITUDE_RESET;
            r_fmt     <= '0;
            r_shift   <= '0;
            r_bp      <= '0;
            r_par     <= 1'b0;
            r_tone    <= 1'b0;
            r_phase   <= '0;
            r_sl      <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_act     <= n_act;
            r_fmt_cfg <= n_fmt_cfg;
            r_amp     <= n_amp;
            r_fmt     <= n_fmt;
            r_shift   <= n_shift;
            r_bp      <= n_bp;
            r_par     <= n_par;
            r_tone    <= n_tone;
            r_phase   <= n_phase;
            r_sl      <= n_sl;
            r_valid   <= n_valid;
        end
        r_sample <= n_sample;
        r_last   <= n_last;
        r_idle   <= n_idle;
    end

    assign o_valid        = r_valid;
    assign o_sample       = r_sample;
    assign o_segment_last = r_last;
    assign o_idle         = r_idle;

endmodule

/* rtl/core/fsk_framed_byte_modulator.sv */
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_mode, i_data_byte, i_carrier_mark, i_carrier_ticks
// output    out        o_valid / i_stall  o_sample, o_segment_last, o_idle
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// one item per cycle: back end retires a waiting queue entry every clock; i_stall holds ticks
// a tick's sample is registered and appears in the cycle after it leaves the two-entry queue
// from transfer in to sample out an item passes the queue memory, then the output register
// o_stall rises only when the queue is full; i_stall holds the output register
// synchronous reset, no clearing pass; all but queue memory and output data reset
`include "assert_macros.svh"

module fsk_framed_byte_modulator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [fskm_pkg::MODE_W-1:0]          i_mode,
    input  logic [fskm_pkg::BYTE_W-1:0]          i_data_byte,
    input  logic                                 i_carrier_mark,
    input  logic [fskm_pkg::TICKS_W-1:0]         i_carrier_ticks,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [fskm_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                 o_segment_last,
    output logic                                 o_idle,
    input  logic                                 i_cfg_we,
    input  logic [fskm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fskm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    fskm_pkg::t_item  w_push_item;
    fskm_pkg::t_item  w_head_item;
    fskm_pkg::t_qstat w_qstat;
    logic             w_push;
    logic             w_pop;

    fskm_front u_front (
        .i_valid         (i_valid),
        .i_mode          (i_mode),
        .i_data_byte     (i_data_byte),
        .i_carrier_mark  (i_carrier_mark),
        .i_carrier_ticks (i_carrier_ticks),
        .i_qstat         (w_qstat),
        .o_stall         (o_stall),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    fskm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_qstat (w_qstat)
    );

    fskm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_qstat        (w_qstat),
        .i_item         (w_head_item),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample       (o_sample),
        .o_segment_last (o_segment_last),
        .o_idle         (o_idle)
    );

    `ASSERT_ALWAYS(a_queue_bound, w_qstat.count <= fskm_pkg::QCNT_W'(fskm_pkg::QUEUE_DEPTH), "queue count beyond depth")
    `ASSERT_IMPLY(a_pop_nonempty, w_pop, !w_qstat.empty, "pop from empty queue")
    `ASSERT_IMPLY(a_idle_silent, o_valid && o_idle, o_sample == '0 && !o_segment_last, "idle sample not silent")
    `ASSERT_NEXT(a_full_holds, w_qstat.full && !w_pop, w_qstat.full, "full queue drained without pop")

endmodule
